/* src/lbcm_pkg.sv */
// ----------------------------------------------------------------------------
// lbcm_pkg
// Shared types and constants for the light box culling mask block.
// ----------------------------------------------------------------------------
package lbcm_pkg;

    // Light count limit; bits past the mask width are never set.
    localparam int MAX_LIGHTS  = 32;
    localparam int MASK_W      = 32;
    localparam int MASK_AW     = $clog2(MASK_W);
    localparam int LIGHT_LIMIT = (MAX_LIGHTS < MASK_W) ? MAX_LIGHTS : MASK_W;
    localparam int IDX_W       = 6;
    localparam logic [IDX_W-1:0] IDX_SAT = {IDX_W{1'b1}};

    // Arithmetic widths: positions Q23.8, axes Q1.14, products at Q.22.
    localparam int POS_W     = 32;
    localparam int AXIS_W    = 16;
    localparam int AXIS_FRAC = 14;
    localparam int RAD_W     = 31;
    localparam int DIFF_W    = POS_W + 1;
    localparam int PROD_W    = DIFF_W + AXIS_W;
    localparam int DOT_W     = PROD_W + 2;
    localparam int CMP_W     = DOT_W + 2;

    // Queue between the front and the back.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Item kinds.
    typedef enum logic [2:0] {
        KIND_ORIGIN   = 3'd0,
        KIND_AXIS0    = 3'd1,
        KIND_AXIS1    = 3'd2,
        KIND_AXIS2    = 3'd3,
        KIND_BOX_LOW  = 3'd4,
        KIND_BOX_HIGH = 3'd5,
        KIND_LIGHT    = 3'd6,
        KIND_NONE     = 3'd7
    } t_kind;

    typedef struct packed {
        logic [2:0]              kind;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic [RAD_W-1:0]        radius;
        logic                    no_light;
        logic                    last;
    } t_in_item;

    typedef struct packed {
        logic [MASK_W-1:0] light_mask;
        logic              any_light;
    } t_out_item;

    // Queue entry: a classified item.
    typedef struct packed {
        t_kind                   op;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic [RAD_W-1:0]        radius;
        logic                    no_light;
        logic                    emits;
    } t_qent;

    typedef struct packed {
        logic [Q_CW-1:0] count;
    } t_q_status;

    // Outcome of the transform pipeline for one item.
    typedef struct packed {
        logic valid;
        logic is_box;
        logic no_light;
        logic emits;
        logic touch;
    } t_cull_res;

endpackage

/* src/lbcm_front.sv */
// ----------------------------------------------------------------------------
// lbcm_front
// Accepts input items, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module lbcm_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lbcm_pkg::t_in_item  i_in_item,
    output logic                o_q_valid,
    output lbcm_pkg::t_qent     o_q_head,
    input  logic                i_q_pop,
    output lbcm_pkg::t_q_status o_q_status
);
    import lbcm_pkg::*;

    t_qent           r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_CW-1:0] r_count;
    logic [Q_CW-1:0] n_count;
    t_qent           w_ent;
    logic            w_push;
    t_kind           w_kind;

    assign w_kind     = t_kind'(i_in_item.kind);
    assign o_in_stall = (r_count == Q_CW'(Q_DEPTH));
    assign o_q_valid  = (r_count != '0);
    assign o_q_head   = r_mem[r_rd_ptr];
    assign o_q_status.count = r_count;

    // Unknown kinds are taken and dropped here.
    always_comb begin
        w_ent.op       = w_kind;
        w_ent.x        = i_in_item.x;
        w_ent.y        = i_in_item.y;
        w_ent.z        = i_in_item.z;
        w_ent.radius   = i_in_item.radius;
        w_ent.no_light = i_in_item.no_light;
        w_ent.emits    = 1'b0;
        w_push         = i_in_valid && !o_in_stall;
        case (w_kind)
            KIND_BOX_HIGH, KIND_LIGHT: w_ent.emits = i_in_item.last;
            KIND_NONE:                 w_push = 1'b0;
            default:                   w_ent.emits = 1'b0;
        endcase
    end

    always_comb begin
        n_count = r_count;
        case ({w_push, i_q_pop})
            2'b10:   n_count = r_count + Q_CW'(1);
            2'b01:   n_count = r_count - Q_CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (i_q_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_ent;
        end
    end

endmodule

/* src/lbcm_xform.sv */
// ----------------------------------------------------------------------------
// lbcm_xform
// Holds the model frame and moves each light into it, then tests the box.
// ----------------------------------------------------------------------------
module lbcm_xform (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  lbcm_pkg::t_qent     i_q_head,
    output logic                o_q_pop,
    input  logic                i_advance,
    output lbcm_pkg::t_cull_res o_cull
);
    import lbcm_pkg::*;

    // Frame state.
    logic signed [POS_W-1:0]  r_origin [3];
    logic signed [AXIS_W-1:0] r_axis   [9];
    logic signed [POS_W-1:0]  r_box_lo [3];
    logic signed [POS_W-1:0]  r_box_hi [3];

    // Stage 1: offset from origin, frame snapshot.
    logic                     r_s1_valid;
    logic                     r_s1_box, r_s1_nol, r_s1_emits;
    logic signed [DIFF_W-1:0] r_s1_d   [3];
    logic signed [AXIS_W-1:0] r_s1_ax  [9];
    logic signed [POS_W-1:0]  r_s1_lo  [3];
    logic signed [POS_W-1:0]  r_s1_hi  [3];
    logic [RAD_W-1:0]         r_s1_rad;

    // Stage 2: nine products.
    logic                     r_s2_valid;
    logic                     r_s2_box, r_s2_nol, r_s2_emits;
    logic signed [PROD_W-1:0] r_s2_p   [9];
    logic signed [POS_W-1:0]  r_s2_lo  [3];
    logic signed [POS_W-1:0]  r_s2_hi  [3];
    logic [RAD_W-1:0]         r_s2_rad;

    // Stage 3: the three dot products.
    logic                     r_s3_valid;
    logic                     r_s3_box, r_s3_nol, r_s3_emits;
    logic signed [DOT_W-1:0]  r_s3_t   [3];
    logic signed [POS_W-1:0]  r_s3_lo  [3];
    logic signed [POS_W-1:0]  r_s3_hi  [3];
    logic [RAD_W-1:0]         r_s3_rad;

    // Stage 4: outcome.
    logic                     r_s4_valid;
    logic                     r_s4_box, r_s4_nol, r_s4_emits, r_s4_touch;

    logic signed [POS_W-1:0]  w_pos [3];
    logic signed [CMP_W-1:0]  w_rad;
    logic signed [CMP_W-1:0]  w_over_hi [3];
    logic signed [CMP_W-1:0]  w_over_lo [3];
    logic                     w_touch;

    assign o_q_pop = i_q_valid && i_advance;
    assign w_pos[0] = i_q_head.x;
    assign w_pos[1] = i_q_head.y;
    assign w_pos[2] = i_q_head.z;

    always_comb begin
        o_cull.valid    = r_s4_valid;
        o_cull.is_box   = r_s4_box;
        o_cull.no_light = r_s4_nol;
        o_cull.emits    = r_s4_emits;
        o_cull.touch    = r_s4_touch;
    end

    // Frame writes happen as the item leaves the queue, so every later light
    // sees them and earlier lights carry their own snapshot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_origin[i] <= '0;
                r_box_lo[i] <= '0;
                r_box_hi[i] <= '0;
            end
            for (int i = 0; i < 9; i++) begin
                r_axis[i] <= '0;
            end
        end else if (o_q_pop) begin
            case (i_q_head.op)
                KIND_ORIGIN: begin
                    for (int c = 0; c < 3; c++) r_origin[c] <= w_pos[c];
                end
                KIND_AXIS0: begin
                    for (int c = 0; c < 3; c++) r_axis[c] <= w_pos[c][AXIS_W-1:0];
                end
                KIND_AXIS1: begin
                    for (int c = 0; c < 3; c++) r_axis[3+c] <= w_pos[c][AXIS_W-1:0];
                end
                KIND_AXIS2: begin
                    for (int c = 0; c < 3; c++) r_axis[6+c] <= w_pos[c][AXIS_W-1:0];
                end
                KIND_BOX_LOW: begin
                    for (int c = 0; c < 3; c++) r_box_lo[c] <= w_pos[c];
                end
                KIND_BOX_HIGH: begin
                    for (int c = 0; c < 3; c++) r_box_hi[c] <= w_pos[c];
                end
                default: begin
                end
            endcase
        end
    end

    // Valid bits of the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else if (i_advance) begin
            r_s1_valid <= o_q_pop && (i_q_head.op == KIND_BOX_HIGH ||
                                      i_q_head.op == KIND_LIGHT);
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_comb begin
        w_rad   = $signed(CMP_W'({r_s3_rad, {AXIS_FRAC{1'b0}}}));
        w_touch = 1'b1;
        for (int r = 0; r < 3; r++) begin
            w_over_hi[r] = CMP_W'(r_s3_t[r])
                         - CMP_W'($signed({r_s3_hi[r], {AXIS_FRAC{1'b0}}}));
            w_over_lo[r] = CMP_W'($signed({r_s3_lo[r], {AXIS_FRAC{1'b0}}}))
                         - CMP_W'(r_s3_t[r]);
            if (w_over_hi[r] > w_rad || w_over_lo[r] > w_rad) begin
                w_touch = 1'b0;
            end
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_s1_box   <= (i_q_head.op == KIND_BOX_HIGH);
            r_s1_nol   <= i_q_head.no_light;
            r_s1_emits <= i_q_head.emits;
            r_s1_rad   <= i_q_head.radius;
            for (int c = 0; c < 3; c++) begin
                r_s1_d[c]  <= DIFF_W'(w_pos[c]) - DIFF_W'(r_origin[c]);
                r_s1_lo[c] <= r_box_lo[c];
                r_s1_hi[c] <= r_box_hi[c];
            end
            for (int i = 0; i < 9; i++) begin
                r_s1_ax[i] <= r_axis[i];
            end

            r_s2_box   <= r_s1_box;
            r_s2_nol   <= r_s1_nol;
            r_s2_emits <= r_s1_emits;
            r_s2_rad   <= r_s1_rad;
            r_s2_lo    <= r_s1_lo;
            r_s2_hi    <= r_s1_hi;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_s2_p[r*3+c] <= PROD_W'(r_s1_d[c] * r_s1_ax[r*3+c]);
                end
            end

            r_s3_box   <= r_s2_box;
            r_s3_nol   <= r_s2_nol;
            r_s3_emits <= r_s2_emits;
            r_s3_rad   <= r_s2_rad;
            r_s3_lo    <= r_s2_lo;
            r_s3_hi    <= r_s2_hi;
            for (int r = 0; r < 3; r++) begin
                r_s3_t[r] <= DOT_W'(r_s2_p[r*3]) + DOT_W'(r_s2_p[r*3+1])
                           + DOT_W'(r_s2_p[r*3+2]);
            end

            r_s4_box   <= r_s3_box;
            r_s4_nol   <= r_s3_nol;
            r_s4_emits <= r_s3_emits;
            r_s4_touch <= w_touch;
        end
    end

endmodule

/* src/lbcm_mask.sv */
// ----------------------------------------------------------------------------
// lbcm_mask
// Accumulates the light mask per model and holds the result for transfer.
// ----------------------------------------------------------------------------
module lbcm_mask (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lbcm_pkg::t_cull_res i_cull,
    output logic                o_advance,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lbcm_pkg::t_out_item o_out_item
);
    import lbcm_pkg::*;

    logic              r_suppress, n_suppress;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [MASK_W-1:0] r_mask, n_mask;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;
    logic [MASK_W-1:0] w_result;

    assign o_advance   = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        n_suppress  = r_suppress;
        n_idx       = r_idx;
        n_mask      = r_mask;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_result    = '0;
        if (o_advance) begin
            n_out_valid = 1'b0;
            if (i_cull.valid) begin
                if (i_cull.is_box) begin
                    n_suppress = i_cull.no_light;
                    n_idx      = '0;
                    n_mask     = '0;
                end else begin
                    if (i_cull.touch && r_idx < IDX_W'(LIGHT_LIMIT)) begin
                        n_mask = r_mask | (MASK_W'(1) << r_idx[MASK_AW-1:0]);
                    end
                    if (r_idx != IDX_SAT) begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
                if (i_cull.emits) begin
                    w_result             = n_suppress ? '0 : n_mask;
                    n_out_valid          = 1'b1;
                    n_out.light_mask     = w_result;
                    n_out.any_light      = (w_result != '0);
                    n_idx                = '0;
                    n_mask               = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_suppress  <= 1'b0;
            r_idx       <= '0;
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_suppress  <= n_suppress;
            r_idx       <= n_idx;
            r_mask      <= n_mask;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

/* src/light_box_cull_mask.sv */
// ----------------------------------------------------------------------------
// light_box_cull_mask
// Builds a per-model light mask by testing each light against an oriented box.
// ----------------------------------------------------------------------------
// Path: the item that ends a batch goes through the queue, the four transform
// stages and the mask output register before the batch result is valid.
// Throughput: one item per cycle while the output is not stalled, set by the
// single transform pass; a stalled output backs up into a four-entry queue.
// Reset: synchronous, active low; clears the frame, mask, counters and queue.
// ----------------------------------------------------------------------------
module light_box_cull_mask (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lbcm_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lbcm_pkg::t_out_item o_out_item
);
    import lbcm_pkg::*;

    // The front takes every transfer it can queue. Set-up and light items are
    // kept in order, while unknown kinds are dropped on the way in.
    logic      w_q_valid;
    t_qent     w_q_head;
    logic      w_q_pop;
    t_q_status w_q_status;

    // The back end moves as one: every stage advances whenever the output
    // register is empty or its result is being taken.
    logic      w_advance;
    t_cull_res w_cull;

    lbcm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_q_valid  (w_q_valid),
        .o_q_head   (w_q_head),
        .i_q_pop    (w_q_pop),
        .o_q_status (w_q_status)
    );

    // Frame registers are written as set-up items leave the queue. Each light
    // takes a snapshot of the frame, so later writes cannot disturb it.
    lbcm_xform u_xform (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_head  (w_q_head),
        .o_q_pop   (w_q_pop),
        .i_advance (w_advance),
        .o_cull    (w_cull)
    );

    // The mask stage applies the outcomes in order and presents one result
    // per batch in its output register.
    lbcm_mask u_mask (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cull      (w_cull),
        .o_advance   (w_advance),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // The nonzero flag always agrees with the mask that it accompanies.
    a_any_light: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.any_light == (o_out_item.light_mask != '0)))
        else $error("any_light disagrees with light_mask");

    // An outcome waiting at the end of the pipeline is never lost in a stall.
    a_cull_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cull.valid && !w_advance) |=> w_cull.valid)
        else $error("pipeline outcome dropped while stalled");

    // The queue never holds more than its depth.
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_status.count <= Q_CW'(Q_DEPTH))
        else $error("queue overflow");

    // Nothing leaves an empty queue.
    a_q_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_status.count != '0)
        else $error("pop from empty queue");

endmodule
